@@ hw/rtl/spvg_pkg.sv @@
package spvg_pkg;

    localparam int PTS_W  = 6;
    localparam int DNS_W  = 4;
    localparam int RAD_W  = 16;
    localparam int ANG_W  = 16;
    localparam int XY_W   = 18;
    localparam int IDX_W  = 6;

    localparam int MAX_POINTS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MIN_POINTS       = 3;

    localparam int TRIG_W  = 18;
    localparam int DIFF_W  = 19;
    localparam int M_W     = 24;
    localparam int B_W     = 26;
    localparam int IXY_W   = 22;
    localparam int MA_W    = 25;
    localparam int MB_W    = 22;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DIV_NW  = 43;
    localparam int DIV_DW  = 26;
    localparam int SQ_W    = 42;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int IR_W    = 18;
    localparam int CORD_XW = 27;
    localparam int CORD_ZW = 33;
    localparam int ATAN_N  = 24;
    localparam int ATAN_IW = 5;
    localparam int SEC_N   = 33;

    localparam int SLOPE_LIMIT = 6554;
    localparam int ICLAMP      = 1048576;
    localparam int IR_MAX      = 262143;
    localparam int XY_MAX      = 131071;
    localparam int XY_MIN      = -131072;
    localparam int CORD_X0     = 10188012;

    localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'd536870912, 32'd316933406, 32'd167458747, 32'd85005430,
        32'd42667175,  32'd21354226,  32'd10679769,  32'd5340240,
        32'd2670157,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // half-turn divided by point count
    localparam logic [ANG_W-1:0] SECTOR_TAB [0:SEC_N-1] = '{
        16'd0,     16'd0,    16'd0,    16'd10922, 16'd8192, 16'd6553,
        16'd5461,  16'd4681, 16'd4096, 16'd3640,  16'd3276, 16'd2978,
        16'd2730,  16'd2520, 16'd2340, 16'd2184,  16'd2048, 16'd1927,
        16'd1820,  16'd1724, 16'd1638, 16'd1560,  16'd1489, 16'd1424,
        16'd1365,  16'd1310, 16'd1260, 16'd1213,  16'd1170, 16'd1129,
        16'd1092,  16'd1057, 16'd1024
    };

    typedef enum logic [4:0] {
        S_IDLE, S_TRIG_GO, S_TRIG_WAIT, S_CHORD, S_SLOPE_WAIT, S_B_MUL, S_B_SET,
        S_FAULT_CHK, S_FAULT_EMIT, S_IX_WAIT, S_IY_MUL, S_IY_SET, S_SQX, S_SQY,
        S_SQSUM, S_ROOT_WAIT, S_IR_MUL, S_IR_SET, S_V_GO, S_V_WAIT, S_V_MULX,
        S_V_MULY, S_V_YCAP, S_V_EMIT
    } t_state;

    function automatic logic signed [IXY_W-1:0] clamp_ixy(input logic signed [43:0] v);
        if (v > 44'sd1048576) begin
            return IXY_W'(ICLAMP);
        end else if (v < -44'sd1048576) begin
            return IXY_W'(-ICLAMP);
        end
        return v[IXY_W-1:0];
    endfunction

    function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [30:0] v);
        if (v > 31'sd131071) begin
            return XY_W'(XY_MAX);
        end else if (v < -31'sd131072) begin
            return XY_W'(XY_MIN);
        end
        return v[XY_W-1:0];
    endfunction

endpackage

@@ hw/rtl/spvg_if.sv @@
interface spvg_req_if;
    import spvg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PTS_W-1:0] points;
    logic [DNS_W-1:0] density;
    logic [RAD_W-1:0] radius;
    logic [ANG_W-1:0] rotation;
    modport source (output valid, points, density, radius, rotation, input ready);
    modport sink   (input valid, points, density, radius, rotation, output ready);
endinterface

interface spvg_vtx_if;
    import spvg_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [IDX_W-1:0]       vertex_index;
    logic                   last;
    logic                   fault;
    modport source (output valid, x, y, vertex_index, last, fault, input ready);
    modport sink   (input valid, x, y, vertex_index, last, fault, output ready);
endinterface

@@ hw/rtl/spvg_cordic.sv @@
module spvg_cordic #(
    parameter int STEPS = spvg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [spvg_pkg::ANG_W-1:0]         i_angle,
    output logic                               o_done,
    output logic signed [spvg_pkg::TRIG_W-1:0] o_cos,
    output logic signed [spvg_pkg::TRIG_W-1:0] o_sin
);
    import spvg_pkg::*;

    logic                      r_busy;
    logic                      r_done;
    logic                      r_neg;
    logic [ATAN_IW-1:0]        r_i;
    logic signed [CORD_XW-1:0] r_x, r_y;
    logic signed [CORD_ZW-1:0] r_z;

    logic signed [ANG_W:0]     sa, zf;
    logic                      negf;
    logic signed [CORD_ZW-1:0] z0, at;
    logic signed [CORD_XW-1:0] tx, ty, xn, yn, xr, yr;

    always_comb begin
        sa   = {i_angle[ANG_W-1], i_angle};
        zf   = sa;
        negf = 1'b0;
        if (sa > 17'sd16384) begin
            zf   = sa - 17'sd32768;
            negf = 1'b1;
        end else if (sa < -17'sd16384) begin
            zf   = sa + 17'sd32768;
            negf = 1'b1;
        end
        z0 = {zf, 16'b0};
        tx = r_y >>> r_i;
        ty = r_x >>> r_i;
        at = $signed({1'b0, ATAN_TAB[r_i]});
        xn = r_neg ? -r_x : r_x;
        yn = r_neg ? -r_y : r_y;
        xr = xn + 27'sd128;
        yr = yn + 27'sd128;
    end

    assign o_done = r_done;
    assign o_cos  = xr[TRIG_W+7:8];
    assign o_sin  = yr[TRIG_W+7:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == ATAN_IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORD_XW'(CORD_X0);
            r_y   <= '0;
            r_z   <= z0;
            r_neg <= negf;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - tx;
                r_y <= r_y + ty;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + tx;
                r_y <= r_y - ty;
                r_z <= r_z + at;
            end
        end
    end

endmodule

@@ hw/rtl/spvg_div.sv @@
module spvg_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [spvg_pkg::DIV_NW-1:0] i_num,
    input  logic signed [spvg_pkg::DIV_DW-1:0] i_den,
    output logic                               o_done,
    output logic signed [spvg_pkg::DIV_NW-1:0] o_quot
);
    import spvg_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_d;

    logic [DIV_NW-1:0] num_mag;
    logic [DIV_DW-1:0] den_mag;
    logic [DIV_DW:0]   rem_sh, diff;
    logic              ge;

    always_comb begin
        num_mag = i_num[DIV_NW-1] ? DIV_NW'(-i_num) : DIV_NW'(i_num);
        den_mag = i_den[DIV_DW-1] ? DIV_DW'(-i_den) : DIV_DW'(i_den);
        rem_sh  = {r_rem, r_q[DIV_NW-1]};
        ge      = rem_sh >= {1'b0, r_d};
        diff    = rem_sh - {1'b0, r_d};
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_d   <= den_mag;
            r_rem <= '0;
            r_neg <= i_num[DIV_NW-1] ^ i_den[DIV_DW-1];
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], ge};
            r_rem <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

endmodule

@@ hw/rtl/spvg_isqrt.sv @@
module spvg_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spvg_pkg::SQ_W-1:0]   i_val,
    output logic                        o_done,
    output logic [spvg_pkg::ROOT_W-1:0] o_root
);
    import spvg_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_v, r_r, r_bit;
    logic [SQ_W-1:0]  t;

    assign t      = r_r + r_bit;
    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_v >= t) begin
                r_v <= r_v - t;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

@@ hw/rtl/star_polygon_vertex_generator.sv @@
// Star polygon vertex generator.
// i_req carries one star request (points, density, radius, rotation); a transfer
// happens when valid and ready are both high. ready is high only while the block
// is idle, so one request is worked on at a time.
// o_vtx carries the results: 2*points vertices in outline order, even index on
// the outer radius and odd on the inner, last set on the final one. Chords that
// are near parallel, vertical together or degenerate give one item with fault
// and last set and zero coordinates.
// Setup runs four CORDIC rotations, up to three divisions and one square root.
// Each vertex then needs one CORDIC rotation and two passes through the shared
// multiplier.
// A one-entry output register holds each result; when the receiver stalls, the
// sequencer holds at the next vertex until that register frees.
// Reset is synchronous: the block returns to idle and drops any pending result.
module star_polygon_vertex_generator #(
    parameter int MAX_POINTS   = spvg_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = spvg_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spvg_req_if.sink    i_req,
    spvg_vtx_if.source  o_vtx
);
    import spvg_pkg::*;

    t_state r_state, n_state;

    logic [PTS_W-1:0]         r_p;
    logic [RAD_W-1:0]         r_rad;
    logic [ANG_W-1:0]         r_rot, r_sector, r_span;
    logic [1:0]               r_tsel;
    logic                     r_csel;
    logic signed [TRIG_W-1:0] r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y, r_p3x, r_p3y;
    logic                     r_degen, r_v1, r_v2;
    logic signed [M_W-1:0]    r_m1, r_m2;
    logic signed [B_W-1:0]    r_b1, r_b2;
    logic                     r_isel;
    logic signed [IXY_W-1:0]  r_ix, r_iy;
    logic [SQ_W-1:0]          r_sq;
    logic [ROOT_W-1:0]        r_ratio;
    logic [IR_W-1:0]          r_ir;
    logic [IDX_W-1:0]         r_k;
    logic [ANG_W-1:0]         r_angle;
    logic signed [TRIG_W-1:0] r_vc, r_vs;
    logic signed [XY_W-1:0]   r_vx, r_vy;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_ovalid;
    logic signed [XY_W-1:0]   r_ox, r_oy;
    logic [IDX_W-1:0]         r_oidx;
    logic                     r_olast, r_ofault;

    logic                     c_start, c_done;
    logic [ANG_W-1:0]         c_angle;
    logic signed [TRIG_W-1:0] c_cos, c_sin;
    logic                     d_start, d_done;
    logic signed [DIV_NW-1:0] d_num, d_quot;
    logic signed [DIV_DW-1:0] d_den;
    logic                     s_start, s_done;
    logic [SQ_W-1:0]          s_val;
    logic [ROOT_W-1:0]        s_root;

    logic [PTS_W-1:0]         p_sat;
    logic [ANG_W-1:0]         sector_in, two_sec, t_angle;
    logic [20:0]              span_full;
    logic signed [TRIG_W-1:0] cx0, cy0, cx1, cy1;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        adx, ady;
    logic                     vert_c, degen_c;
    logic signed [M_W-1:0]    m_csel, m_isel;
    logic signed [B_W-1:0]    b_isel;
    logic signed [M_W:0]      dm;
    logic [M_W:0]             adm;
    logic signed [B_W:0]      db;
    logic                     fault_c, o_free, v_last;
    logic signed [30:0]       prod_hi, rnd_hi;
    logic signed [PROD_W-1:0] rnd;
    logic signed [31:0]       b_calc, iy_calc;
    logic [IR_W-1:0]          vr;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;

    spvg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (c_angle),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    spvg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    spvg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_val   (s_val),
        .o_done  (s_done),
        .o_root  (s_root)
    );

    always_comb begin
        p_sat = i_req.points;
        if (p_sat < PTS_W'(MIN_POINTS)) begin
            p_sat = PTS_W'(MIN_POINTS);
        end else if (p_sat > PTS_W'(MAX_POINTS)) begin
            p_sat = PTS_W'(MAX_POINTS);
        end
        sector_in = SECTOR_TAB[p_sat];
        span_full = 21'({sector_in, 1'b0}) * 21'(i_req.density);
        two_sec   = {r_sector[ANG_W-2:0], 1'b0};
        unique case (r_tsel)
            2'd0:    t_angle = '0;
            2'd1:    t_angle = r_span;
            2'd2:    t_angle = two_sec;
            default: t_angle = two_sec - r_span;
        endcase

        cx0 = r_csel ? r_p2x : r_p0x;
        cy0 = r_csel ? r_p2y : r_p0y;
        cx1 = r_csel ? r_p3x : r_p1x;
        cy1 = r_csel ? r_p3y : r_p1y;
        dx  = DIFF_W'(cx1) - DIFF_W'(cx0);
        dy  = DIFF_W'(cy1) - DIFF_W'(cy0);
        adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        degen_c = (dx == '0) && (dy == '0);
        vert_c  = (dx == '0) || ({7'b0, ady} >= {adx, 7'b0});

        m_csel = r_csel ? r_m2 : r_m1;
        m_isel = r_isel ? r_m2 : r_m1;
        b_isel = r_isel ? r_b2 : r_b1;
        dm  = (M_W + 1)'(r_m1) - (M_W + 1)'(r_m2);
        adm = dm[M_W] ? (M_W + 1)'(-dm) : (M_W + 1)'(dm);
        db  = (B_W + 1)'(r_b2) - (B_W + 1)'(r_b1);
        fault_c = r_degen || (r_v1 && r_v2) ||
                  (!r_v1 && !r_v2 && (adm < (M_W + 1)'(SLOPE_LIMIT)));

        prod_hi = $signed(r_prod[PROD_W-1:16]);
        rnd     = r_prod + PROD_W'(32768);
        rnd_hi  = $signed(rnd[PROD_W-1:16]);
        b_calc  = 32'(cy0) - 32'(prod_hi);
        iy_calc = 32'(prod_hi) + 32'(b_isel);
        vr      = r_k[0] ? r_ir : IR_W'(r_rad);
        v_last  = ({1'b0, r_k} == ({r_p, 1'b0} - 7'd1));
        o_free  = !r_ovalid || o_vtx.ready;
        s_val   = r_sq + r_prod[SQ_W-1:0];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_B_MUL: begin
                mul_a = MA_W'(m_csel);
                mul_b = MB_W'(cx0);
            end
            S_IY_MUL: begin
                mul_a = MA_W'(m_isel);
                mul_b = r_ix;
            end
            S_SQX: begin
                mul_a = MA_W'(r_ix);
                mul_b = r_ix;
            end
            S_SQY: begin
                mul_a = MA_W'(r_iy);
                mul_b = r_iy;
            end
            S_IR_MUL: begin
                mul_a = $signed({9'b0, r_rad});
                mul_b = $signed({1'b0, r_ratio});
            end
            S_V_MULX: begin
                mul_a = $signed({7'b0, vr});
                mul_b = MB_W'(r_vc);
            end
            S_V_MULY: begin
                mul_a = $signed({7'b0, vr});
                mul_b = MB_W'(r_vs);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        c_start = 1'b0;
        c_angle = t_angle;
        d_start = 1'b0;
        d_num   = DIV_NW'(dy) <<< 16;
        d_den   = DIV_DW'(dx);
        s_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_TRIG_GO;
                end
            end
            S_TRIG_GO: begin
                c_start = 1'b1;
                n_state = S_TRIG_WAIT;
            end
            S_TRIG_WAIT: begin
                if (c_done) begin
                    n_state = (r_tsel == 2'd3) ? S_CHORD : S_TRIG_GO;
                end
            end
            S_CHORD: begin
                if (!degen_c && !vert_c) begin
                    d_start = 1'b1;
                    n_state = S_SLOPE_WAIT;
                end else begin
                    n_state = r_csel ? S_FAULT_CHK : S_CHORD;
                end
            end
            S_SLOPE_WAIT: begin
                if (d_done) begin
                    n_state = S_B_MUL;
                end
            end
            S_B_MUL: n_state = S_B_SET;
            S_B_SET: n_state = r_csel ? S_FAULT_CHK : S_CHORD;
            S_FAULT_CHK: begin
                d_num = {db, 16'b0};
                d_den = DIV_DW'(dm);
                if (fault_c) begin
                    n_state = S_FAULT_EMIT;
                end else if (r_v1 || r_v2) begin
                    n_state = S_IY_MUL;
                end else begin
                    d_start = 1'b1;
                    n_state = S_IX_WAIT;
                end
            end
            S_FAULT_EMIT: begin
                if (o_free) begin
                    n_state = S_IDLE;
                end
            end
            S_IX_WAIT: begin
                if (d_done) begin
                    n_state = S_IY_MUL;
                end
            end
            S_IY_MUL: n_state = S_IY_SET;
            S_IY_SET: n_state = S_SQX;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_SQSUM;
            S_SQSUM: begin
                s_start = 1'b1;
                n_state = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (s_done) begin
                    n_state = S_IR_MUL;
                end
            end
            S_IR_MUL: n_state = S_IR_SET;
            S_IR_SET: n_state = S_V_GO;
            S_V_GO: begin
                c_start = 1'b1;
                c_angle = r_angle;
                n_state = S_V_WAIT;
            end
            S_V_WAIT: begin
                if (c_done) begin
                    n_state = S_V_MULX;
                end
            end
            S_V_MULX: n_state = S_V_MULY;
            S_V_MULY: n_state = S_V_YCAP;
            S_V_YCAP: n_state = S_V_EMIT;
            S_V_EMIT: begin
                if (o_free) begin
                    n_state = v_last ? S_IDLE : S_V_GO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_p      <= p_sat;
                r_rad    <= i_req.radius;
                r_rot    <= i_req.rotation;
                r_sector <= sector_in;
                r_span   <= span_full[ANG_W-1:0];
                r_tsel   <= '0;
                r_csel   <= 1'b0;
                r_degen  <= 1'b0;
            end
            S_TRIG_WAIT: begin
                if (c_done) begin
                    r_tsel <= r_tsel + 1'b1;
                    unique case (r_tsel)
                        2'd0: begin
                            r_p0x <= c_cos;
                            r_p0y <= c_sin;
                        end
                        2'd1: begin
                            r_p1x <= c_cos;
                            r_p1y <= c_sin;
                        end
                        2'd2: begin
                            r_p2x <= c_cos;
                            r_p2y <= c_sin;
                        end
                        default: begin
                            r_p3x <= c_cos;
                            r_p3y <= c_sin;
                        end
                    endcase
                end
            end
            S_CHORD: begin
                if (degen_c) begin
                    r_degen <= 1'b1;
                end
                if (r_csel) begin
                    r_v2 <= vert_c && !degen_c;
                    r_m2 <= '0;
                    r_b2 <= '0;
                end else begin
                    r_v1 <= vert_c && !degen_c;
                    r_m1 <= '0;
                    r_b1 <= '0;
                end
                if (degen_c || vert_c) begin
                    r_csel <= 1'b1;
                end
            end
            S_SLOPE_WAIT: begin
                if (d_done) begin
                    if (r_csel) begin
                        r_m2 <= d_quot[M_W-1:0];
                    end else begin
                        r_m1 <= d_quot[M_W-1:0];
                    end
                end
            end
            S_B_SET: begin
                if (r_csel) begin
                    r_b2 <= b_calc[B_W-1:0];
                end else begin
                    r_b1 <= b_calc[B_W-1:0];
                end
                r_csel <= 1'b1;
            end
            S_FAULT_CHK: begin
                if (r_v1) begin
                    r_ix   <= IXY_W'(r_p0x);
                    r_isel <= 1'b1;
                end else begin
                    r_ix   <= IXY_W'(r_p2x);
                    r_isel <= 1'b0;
                end
            end
            S_IX_WAIT: begin
                if (d_done) begin
                    r_ix   <= clamp_ixy(44'(d_quot));
                    r_isel <= 1'b0;
                end
            end
            S_IY_SET: r_iy <= clamp_ixy(44'(iy_calc));
            S_SQY:    r_sq <= r_prod[SQ_W-1:0];
            S_ROOT_WAIT: begin
                if (s_done) begin
                    r_ratio <= s_root;
                end
            end
            S_IR_SET: begin
                r_ir    <= (rnd_hi > 31'sd262143) ? IR_W'(IR_MAX) : rnd_hi[IR_W-1:0];
                r_k     <= '0;
                r_angle <= r_rot;
            end
            S_V_WAIT: begin
                if (c_done) begin
                    r_vc <= c_cos;
                    r_vs <= c_sin;
                end
            end
            S_V_MULY: r_vx <= sat_xy(rnd_hi);
            S_V_YCAP: r_vy <= sat_xy(rnd_hi);
            S_V_EMIT: begin
                if (o_free) begin
                    r_k     <= r_k + 1'b1;
                    r_angle <= r_angle + r_sector;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_free && (r_state == S_V_EMIT || r_state == S_FAULT_EMIT)) begin
            r_ovalid <= 1'b1;
        end else if (o_vtx.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_state == S_V_EMIT) begin
            r_ox     <= r_vx;
            r_oy     <= r_vy;
            r_oidx   <= r_k;
            r_olast  <= v_last;
            r_ofault <= 1'b0;
        end else if (o_free && r_state == S_FAULT_EMIT) begin
            r_ox     <= '0;
            r_oy     <= '0;
            r_oidx   <= '0;
            r_olast  <= 1'b1;
            r_ofault <= 1'b1;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_vtx.valid        = r_ovalid;
    assign o_vtx.x            = r_ox;
    assign o_vtx.y            = r_oy;
    assign o_vtx.vertex_index = r_oidx;
    assign o_vtx.last         = r_olast;
    assign o_vtx.fault        = r_ofault;

    a_fault_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.fault) |-> (o_vtx.last && o_vtx.vertex_index == '0))
        else $error("fault result without last or with nonzero index");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while a request is in progress");

    a_last_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.last && !o_vtx.fault) |-> o_vtx.vertex_index[0])
        else $error("final vertex is not on the inner radius");

    a_cordic_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_TRIG_WAIT || r_state == S_V_WAIT))
        else $error("rotation finished outside a wait state");

endmodule

@@ bench/star_polygon_vertex_generator_tb.sv @@
`timescale 1ns / 100ps

module star_polygon_vertex_generator_tb;
    import spvg_pkg::*;

    typedef struct packed {
        logic [PTS_W-1:0] points;
        logic [DNS_W-1:0] density;
        logic [RAD_W-1:0] radius;
        logic [ANG_W-1:0] rotation;
    } t_star;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [IDX_W-1:0]       vertex_index;
        logic                   last;
        logic                   fault;
    } t_vertex;

    typedef struct {
        t_star req;
        bit    has_fixed;
        int    fixed_count;
        bit    fixed_fault;
    } t_row;

    localparam int STEPS     = CORDIC_STEPS_DEF;
    localparam int N_RANDOM  = 330;
    localparam int SETTLE    = 3000;

    logic i_clk;
    logic i_rst_n;

    spvg_req_if i_req ();
    spvg_vtx_if o_vtx ();

    star_polygon_vertex_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.sink),
        .o_vtx   (o_vtx.source)
    );

    t_vertex vertex_queue[$];
    int      errors;
    int      n_requests;
    int      n_vertices;
    int      n_faults;
    int      n_pushed;
    bit      long_stall;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint iabs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_turn(input int i);
        longint tab[24] = '{536870912, 316933406, 167458747, 85005430, 42667175,
                            21354226, 10679769, 5340240, 2670157, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                            1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    task automatic cordic(input logic [ANG_W-1:0] ang, output longint c, output longint s);
        longint z, x, y, tx, ty;
        bit     flip;
        z = longint'(signed'({ang, 16'h0000}));
        x = 10188012;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            tx = asr(y, i);
            ty = asr(x, i);
            if (z >= 0) begin
                x -= tx; y += ty; z -= atan_turn(i);
            end else begin
                x += tx; y -= ty; z += atan_turn(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = asr(x + 128, 8);
        s = asr(y + 128, 8);
    endtask

    task automatic chord_line(input logic [ANG_W-1:0] a0, input logic [ANG_W-1:0] a1,
                              output bit ok, output bit vert, output longint ax,
                              output longint m, output longint b);
        longint x0, y0, x1, y1, dx, dy;
        cordic(a0, x0, y0);
        cordic(a1, x1, y1);
        dx = x1 - x0;
        dy = y1 - y0;
        ax = x0;
        m = 0;
        b = 0;
        vert = 1'b0;
        ok = !(dx == 0 && dy == 0);
        if (ok) begin
            vert = (dx == 0) || (iabs(dy) >= 128 * iabs(dx));
            if (!vert) begin
                m = dy * 65536 / dx;
                b = y0 - asr(m * x0, 16);
            end
        end
    endtask

    function automatic longint root(input longint v);
        longint r, bitv;
        r = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >>> 1) + bitv;
            end else begin
                r = r >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return r;
    endfunction

    task automatic predict_star(input t_star req);
        int      p, n;
        longint  sector, span, rad, ax1, m1, b1, ax2, m2, b2, ix, iy, ir, c, s, r;
        bit      ok1, ok2, v1, v2;
        t_vertex v;
        p = req.points;
        if (p < MIN_POINTS) p = MIN_POINTS;
        if (p > MAX_POINTS_DEF) p = MAX_POINTS_DEF;
        sector = (65536 / (2 * p)) & 16'hFFFF;
        span = (2 * sector * req.density) & 16'hFFFF;
        rad = req.radius;
        chord_line(16'd0, span[15:0], ok1, v1, ax1, m1, b1);
        chord_line(ANG_W'(2 * sector), ANG_W'(2 * sector - span), ok2, v2, ax2, m2, b2);
        if (!ok1 || !ok2 || (v1 && v2) || (!v1 && !v2 && iabs(m1 - m2) < SLOPE_LIMIT)) begin
            v = '0;
            v.last = 1'b1;
            v.fault = 1'b1;
            vertex_queue.push_back(v);
            n_pushed++;
            return;
        end
        if (v1) begin
            ix = ax1;
            iy = asr(m2 * ix, 16) + b2;
        end else if (v2) begin
            ix = ax2;
            iy = asr(m1 * ix, 16) + b1;
        end else begin
            ix = clampl((b2 - b1) * 65536 / (m1 - m2), -ICLAMP, ICLAMP);
            iy = asr(m1 * ix, 16) + b1;
        end
        ix = clampl(ix, -ICLAMP, ICLAMP);
        iy = clampl(iy, -ICLAMP, ICLAMP);
        ir = (rad * root(ix * ix + iy * iy) + 32768) >>> 16;
        if (ir > IR_MAX) ir = IR_MAX;
        n = 2 * p;
        for (int k = 0; k < n; k++) begin
            r = k[0] ? ir : rad;
            cordic(ANG_W'(req.rotation + k * sector), c, s);
            v.x = XY_W'(clampl(asr(r * c + 32768, 16), XY_MIN, XY_MAX));
            v.y = XY_W'(clampl(asr(r * s + 32768, 16), XY_MIN, XY_MAX));
            v.vertex_index = IDX_W'(k);
            v.last = (k == n - 1);
            v.fault = 1'b0;
            vertex_queue.push_back(v);
            n_pushed++;
        end
    endtask

    task automatic send_star(input t_star req);
        i_req.valid    <= 1'b1;
        i_req.points   <= req.points;
        i_req.density  <= req.density;
        i_req.radius   <= req.radius;
        i_req.rotation <= req.rotation;
        do @(posedge i_clk); while (!i_req.ready);
        predict_star(req);
        n_requests++;
        if ($urandom_range(0, 2) == 0) begin
            i_req.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300)
                                               : $urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic t_star rand_star();
        t_star q;
        q.points   = ($urandom_range(0, 7) == 0) ? PTS_W'($urandom)
                                                 : PTS_W'($urandom_range(3, 10));
        q.density  = ($urandom_range(0, 4) == 0) ? DNS_W'($urandom)
                                                 : DNS_W'($urandom_range(1, q.points / 2));
        q.radius   = ($urandom_range(0, 5) == 0) ? 16'hFFFF : RAD_W'($urandom);
        q.rotation = ANG_W'($urandom);
        return q;
    endfunction

    // ready side: random stalls, one long hold-off counted here
    initial begin
        int hold;
        o_vtx.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_stall) begin
                o_vtx.ready <= 1'b0;
                for (hold = 0; hold < 4000; hold++) @(posedge i_clk);
                long_stall = 1'b0;
            end
            case ($urandom_range(0, 19))
                0: begin
                    o_vtx.ready <= 1'b0;
                    repeat ($urandom_range(30, 200)) @(posedge i_clk);
                end
                1, 2, 3, 4: o_vtx.ready <= 1'b0;
                default: o_vtx.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_vertex got, exp_v;
        if (i_rst_n && o_vtx.valid && o_vtx.ready) begin
            got = '{o_vtx.x, o_vtx.y, o_vtx.vertex_index, o_vtx.last, o_vtx.fault};
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex %p", $time, got);
                errors++;
            end else begin
                exp_v = vertex_queue.pop_front();
                if (got !== exp_v) begin
                    $display("%0t: expected %p actual %p", $time, exp_v, got);
                    errors++;
                end
                n_vertices++;
                if (got.fault) n_faults++;
            end
        end
    end

    initial begin
        #300ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row row;
        int   before_n;
        errors = 0;
        n_requests = 0;
        n_vertices = 0;
        n_faults = 0;
        n_pushed = 0;
        long_stall = 1'b0;
        i_rst_n <= 1'b0;
        i_req.valid <= 1'b0;
        i_req.points <= '0;
        i_req.density <= '0;
        i_req.radius <= '0;
        i_req.rotation <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{'{6'd5, 4'd2, 16'd1600, 16'd0}, 1, 10, 0});
        rows.push_back('{'{6'd5, 4'd0, 16'd1600, 16'd0}, 1, 1, 1});
        rows.push_back('{'{6'd0, 4'd1, 16'd0, 16'd0}, 1, 1, 1});
        rows.push_back('{'{6'd2, 4'd1, 16'hFFFF, 16'hFFFF}, 1, 1, 1});
        rows.push_back('{'{6'd63, 4'd15, 16'hFFFF, 16'h8000}, 1, 64, 0});
        rows.push_back('{'{6'd32, 4'd1, 16'd4000, 16'h4000}, 1, 1, 1});
        rows.push_back('{'{6'd32, 4'd15, 16'd1, 16'hC000}, 1, 64, 0});
        rows.push_back('{'{6'd4, 4'd2, 16'd800, 16'd0}, 0, 0, 0});
        rows.push_back('{'{6'd6, 4'd3, 16'd800, 16'd100}, 0, 0, 0});
        rows.push_back('{'{6'd7, 4'd3, 16'h8000, 16'h2AAA}, 0, 0, 0});
        rows.push_back('{'{6'd8, 4'd4, 16'h7FFF, 16'h5555}, 0, 0, 0});
        rows.push_back('{'{6'd3, 4'd1, 16'hAAAA, 16'hAAAA}, 0, 0, 0});
        rows.push_back('{'{6'd12, 4'd5, 16'h5555, 16'h1234}, 0, 0, 0});
        rows.push_back('{'{6'd21, 4'd8, 16'hFFFF, 16'hFFFF}, 0, 0, 0});
        rows.push_back('{'{6'd16, 4'd7, 16'd16, 16'd1}, 0, 0, 0});
        foreach (rows[i]) begin
            row = rows[i];
            before_n = n_pushed;
            send_star(row.req);
            if (row.has_fixed && (n_pushed - before_n != row.fixed_count ||
                vertex_queue[$].fault != row.fixed_fault)) begin
                $display("%0t: row %0d expected %0d results fault %0b", $time, i,
                         row.fixed_count, row.fixed_fault);
                errors++;
            end
        end
        i_req.valid <= 1'b0;
        wait (vertex_queue.size() == 0);
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 40) long_stall = 1'b1;
            if (i == 150) begin
                i_req.valid <= 1'b0;
                wait (vertex_queue.size() == 0);
                @(posedge i_clk);
            end
            send_star(rand_star());
        end
        i_req.valid <= 1'b0;
        wait (vertex_queue.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("%0d star requests, %0d results checked, %0d of them faults",
                 n_requests, n_vertices, n_faults);
        if (errors == 0 && vertex_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
